@@ rtl/ewa_pkg.sv @@
// Shared types and constants of the exponentially weighted attention accumulator.
package ewa_pkg;

  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_QUERY  = 3'd1;
  localparam logic [2:0] MODE_KEY    = 3'd2;
  localparam logic [2:0] MODE_VALUE  = 3'd3;
  localparam logic [2:0] MODE_FINISH = 3'd4;

  localparam logic CFG_SCORE_SCALE = 1'b0;
  localparam logic CFG_DIM_IN_USE  = 1'b1;

  localparam logic [15:0] SCALE_RST = 16'd8192;
  localparam logic [6:0]  DIM_RST   = 7'd64;

  localparam logic [6:0] DIV_IT_EXP = 7'd46;
  localparam logic [6:0] DIV_IT_RCP = 7'd50;
  localparam logic [6:0] DIV_IT_FIN = 7'd48;
  localparam logic [6:0] EXP_TERMS  = 7'd64;

  typedef enum logic [2:0] {
    OP_START,
    OP_QUERY,
    OP_KEY,
    OP_VALUE,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [5:0]         idx;
    logic signed [15:0] elem;
    logic [15:0]        len;
  } item_t;

  typedef struct packed {
    logic [15:0] scale;
    logic [6:0]  dim;
  } cfg_t;

endpackage

@@ rtl/ewa_if.sv @@
// Stream interfaces for input items and result elements.
interface ewa_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [5:0]         index;
  logic signed [15:0] element;
  logic [15:0]        seq_length;
  modport source (output valid, mode, index, element, seq_length, input ready);
  modport sink (input valid, mode, index, element, seq_length, output ready);
endinterface

interface ewa_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         out_index;
  logic signed [31:0] out_value;
  logic               last;
  modport source (output valid, out_index, out_value, last, input ready);
  modport sink (input valid, out_index, out_value, last, output ready);
endinterface

@@ rtl/ewa_div.sv @@
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
module ewa_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [47:0] divisor_i,
  input  logic [6:0]  iters_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] dvd_q, dvd_d, quot_q, quot_d;
  logic [47:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [48:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[63]};
    ge     = rem_sh >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      dvd_d  = dividend_i;
      quot_d = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? 48'(rem_sh - {1'b0, dsr_q}) : rem_sh[47:0];
      quot_d = {quot_q[62:0], ge};
      dvd_d  = {dvd_q[62:0], 1'b0};
      cnt_d  = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/ewa_front.sv @@
// Front end: accepts beats, drops ignored items, queues work for the back end.
module ewa_front #(
  parameter int MAX_DIM = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ewa_in_if.sink        in_i,
  input  logic [6:0]    dim_i,
  input  logic          pop_i,
  output ewa_pkg::item_t head_o,
  output logic          head_vld_o
);

  ewa_pkg::item_t fifo_q [4];
  ewa_pkg::item_t item;
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       cnt_nz_q;
  logic       keep, push, acc, in_dim;

  always_comb begin
    in_dim   = {1'b0, in_i.index} < dim_i;
    item.idx  = in_i.index;
    item.elem = in_i.element;
    item.len  = in_i.seq_length;
    item.op   = ewa_pkg::OP_START;
    keep      = 1'b0;
    case (in_i.mode)
      ewa_pkg::MODE_START: begin
        keep = 1'b1;
      end
      ewa_pkg::MODE_QUERY: begin
        item.op = ewa_pkg::OP_QUERY;
        keep    = {1'b0, in_i.index} < 7'(MAX_DIM);
      end
      ewa_pkg::MODE_KEY: begin
        item.op = ewa_pkg::OP_KEY;
        keep    = cnt_nz_q && in_dim;
      end
      ewa_pkg::MODE_VALUE: begin
        item.op = ewa_pkg::OP_VALUE;
        keep    = cnt_nz_q && in_dim;
      end
      ewa_pkg::MODE_FINISH: begin
        item.op = ewa_pkg::OP_FINISH;
        keep    = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_i.ready = cnt_q != 3'd4;
  assign acc        = in_i.valid && in_i.ready;
  assign push       = acc && keep;
  assign head_o     = fifo_q[rd_ptr_q];
  assign head_vld_o = cnt_q != 3'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      cnt_nz_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(pop_i);
      if (acc && in_i.mode == ewa_pkg::MODE_START) cnt_nz_q <= in_i.seq_length != 16'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= item;
  end

endmodule

@@ rtl/ewa_back.sv @@
// Back end: query store, dot product, exp weight series, value accumulators, finish.
module ewa_back #(
  parameter int MAX_DIM = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ewa_pkg::cfg_t  cfg_i,
  input  ewa_pkg::item_t head_i,
  input  logic           head_vld_i,
  output logic           pop_o,
  ewa_out_if.source      out_o
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_KRD  = 5'd1;
  localparam logic [4:0] S_KMUL = 5'd2;
  localparam logic [4:0] S_KACC = 5'd3;
  localparam logic [4:0] S_SCL  = 5'd4;
  localparam logic [4:0] S_SRND = 5'd5;
  localparam logic [4:0] S_EADD = 5'd6;
  localparam logic [4:0] S_EMUL = 5'd7;
  localparam logic [4:0] S_EDST = 5'd8;
  localparam logic [4:0] S_EDIV = 5'd9;
  localparam logic [4:0] S_EEND = 5'd10;
  localparam logic [4:0] S_RDIV = 5'd11;
  localparam logic [4:0] S_VRD  = 5'd12;
  localparam logic [4:0] S_VACC = 5'd13;
  localparam logic [4:0] S_FRD  = 5'd14;
  localparam logic [4:0] S_FDST = 5'd15;
  localparam logic [4:0] S_FDIV = 5'd16;
  localparam logic [4:0] S_FOUT = 5'd17;

  logic [4:0] st_q, st_d;
  ewa_pkg::item_t cur_q;

  logic signed [15:0] qmem [MAX_DIM];
  logic [63:0]        amem [MAX_DIM];
  logic signed [15:0] qrd_q;
  logic [63:0]        ard_q;
  logic               ard_vld_q;
  logic [MAX_DIM-1:0] avld_q;
  logic [AW-1:0]      cur_addr, ard_addr;

  logic signed [39:0] dot_q;
  logic signed [31:0] kprod_q;
  logic signed [56:0] p_q;
  logic signed [44:0] vprod_q;
  logic               sneg_q, fneg_q;
  logic [15:0]        a_q;
  logic [41:0]        term_q;
  logic [44:0]        sum_q;
  logic [6:0]         n_q;
  logic [57:0]        tprod_q;
  logic [27:0]        wt_q;
  logic [15:0]        cnt_q;
  logic [5:0]         fi_q;
  logic               out_vld_q, olast_q;
  logic [5:0]         oidx_q;
  logic signed [31:0] oval_q;

  logic               div_start, div_busy, div_done;
  logic [63:0]        div_dvd, div_quot;
  logic [47:0]        div_dsr;
  logic [6:0]         div_it;

  logic signed [56:0] ps;
  logic signed [28:0] s_full;
  logic signed [15:0] s16;
  logic [63:0]        rdv;
  logic signed [47:0] v48;
  logic [47:0]        vmag;
  logic [45:0]        wsum;
  logic [18:0]        rinc;
  logic [31:0]        qsat;
  logic               is_last, slot_free, pop_start;

  assign cur_addr  = cur_q.idx[AW-1:0];
  assign ard_addr  = (st_q == S_FRD) ? fi_q[AW-1:0] : cur_addr;
  assign pop_o     = (st_q == S_IDLE) && head_vld_i;
  assign pop_start = pop_o && head_i.op == ewa_pkg::OP_START;
  assign slot_free = !out_vld_q || out_o.ready;
  assign is_last   = {1'b0, fi_q} == cfg_i.dim - 7'd1;

  always_comb begin
    ps     = p_q + 57'sd134217728;
    s_full = ps[56:28];
    if (s_full > 29'sd32767) s16 = 16'sh7FFF;
    else if (s_full < -29'sd32768) s16 = 16'sh8000;
    else s16 = s_full[15:0];
    rdv  = ard_vld_q ? ard_q : 64'd0;
    v48  = rdv[63:16];
    vmag = v48[47] ? 48'(-v48) : 48'(v48);
    wsum = {1'b0, sum_q} + 46'd32768;
    rinc = {1'b0, div_quot[17:0]} + 19'd1;
    if (!fneg_q) begin
      qsat = (div_quot[47:31] != '0) ? 32'h7FFF_FFFF : div_quot[31:0];
    end else if (div_quot[47:32] != '0 || (div_quot[31] && div_quot[30:0] != '0)) begin
      qsat = 32'h8000_0000;
    end else begin
      qsat = 32'(-div_quot[31:0]);
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {tprod_q[57:12], 18'd0};
    div_dsr   = {41'd0, n_q};
    div_it    = ewa_pkg::DIV_IT_EXP;
    case (st_q)
      S_EDST: div_start = 1'b1;
      S_EEND: begin
        div_start = sneg_q;
        div_dvd   = 64'h8000_0000_0000_0000;
        div_dsr   = {3'd0, sum_q};
        div_it    = ewa_pkg::DIV_IT_RCP;
      end
      S_FDST: begin
        div_start = 1'b1;
        div_dvd   = {vmag, 16'd0};
        div_dsr   = {32'd0, (cnt_q == 16'd0) ? 16'd1 : cnt_q};
        div_it    = ewa_pkg::DIV_IT_FIN;
      end
      default: div_start = 1'b0;
    endcase
  end

  ewa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .iters_i    (div_it),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (pop_o) begin
          case (head_i.op)
            ewa_pkg::OP_KEY:    st_d = S_KRD;
            ewa_pkg::OP_VALUE:  st_d = S_VRD;
            ewa_pkg::OP_FINISH: st_d = S_FRD;
            default:            st_d = S_IDLE;
          endcase
        end
      end
      S_KRD:  st_d = S_KMUL;
      S_KMUL: st_d = S_KACC;
      S_KACC: st_d = ({1'b0, cur_q.idx} == cfg_i.dim - 7'd1) ? S_SCL : S_IDLE;
      S_SCL:  st_d = S_SRND;
      S_SRND: st_d = S_EADD;
      S_EADD: st_d = (n_q == ewa_pkg::EXP_TERMS || term_q == '0) ? S_EEND : S_EMUL;
      S_EMUL: st_d = S_EDST;
      S_EDST: st_d = S_EDIV;
      S_EDIV: if (div_done) st_d = S_EADD;
      S_EEND: st_d = sneg_q ? S_RDIV : S_IDLE;
      S_RDIV: if (div_done) st_d = S_IDLE;
      S_VRD:  st_d = S_VACC;
      S_VACC: st_d = S_IDLE;
      S_FRD:  st_d = S_FDST;
      S_FDST: st_d = S_FDIV;
      S_FDIV: if (div_done) st_d = S_FOUT;
      S_FOUT: if (slot_free) st_d = is_last ? S_IDLE : S_FRD;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      avld_q    <= '0;
      dot_q     <= '0;
      wt_q      <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (pop_start) begin
        avld_q <= '0;
        dot_q  <= '0;
        wt_q   <= '0;
        cnt_q  <= head_i.len;
      end
      if (st_q == S_KACC) dot_q <= dot_q + {{8{kprod_q[31]}}, kprod_q};
      if (st_q == S_SRND) dot_q <= '0;
      if (st_q == S_EEND && !sneg_q) wt_q <= wsum[43:16];
      if (st_q == S_RDIV && div_done) wt_q <= {10'd0, rinc[18:1]};
      if (st_q == S_VACC) avld_q[cur_addr] <= 1'b1;
      if (st_q == S_FOUT && slot_free) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    kprod_q <= qrd_q * cur_q.elem;
    p_q     <= dot_q * $signed({1'b0, cfg_i.scale});
    vprod_q <= $signed({1'b0, wt_q}) * cur_q.elem;
    tprod_q <= term_q * a_q;
    case (st_q)
      S_SRND: begin
        sneg_q <= s16[15];
        a_q    <= s16[15] ? 16'(-s16) : 16'(s16);
        term_q <= 42'h1_0000_0000;
        sum_q  <= '0;
        n_q    <= 7'd1;
      end
      S_EADD: sum_q <= sum_q + {3'd0, term_q};
      S_EDIV: begin
        if (div_done) begin
          term_q <= div_quot[41:0];
          n_q    <= n_q + 7'd1;
        end
      end
      S_FDST: fneg_q <= v48[47];
      S_FOUT: begin
        if (slot_free) begin
          oidx_q  <= fi_q;
          oval_q  <= qsat;
          olast_q <= is_last;
          fi_q    <= fi_q + 6'd1;
        end
      end
      default: ;
    endcase
    if (pop_o && head_i.op == ewa_pkg::OP_FINISH) fi_q <= '0;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.op == ewa_pkg::OP_QUERY) qmem[head_i.idx[AW-1:0]] <= head_i.elem;
    if (st_q == S_VACC) amem[cur_addr] <= rdv + {{19{vprod_q[44]}}, vprod_q};
    qrd_q     <= qmem[cur_addr];
    ard_q     <= amem[ard_addr];
    ard_vld_q <= avld_q[ard_addr];
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_index = oidx_q;
  assign out_o.out_value = oval_q;
  assign out_o.last      = olast_q;

  a_last_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && olast_q |-> {1'b0, oidx_q} == cfg_i.dim - 7'd1)
    else $error("last flag on wrong element");

  a_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EDIV || st_q == S_RDIV || st_q == S_FDIV) |-> (div_busy || div_done))
    else $error("waiting on idle divider");

  a_start_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_start |=> (avld_q == '0 && dot_q == '0 && wt_q == '0))
    else $error("start did not clear accumulators");

endmodule

@@ rtl/exp_weighted_attention_accumulator_core.sv @@
// Top level of the exponentially weighted attention accumulator.
//  channel  dir  handshake              payload
//  in_i     in   in_i.valid/ready       mode, index, element, seq_length
//  out_o    out  out_o.valid/ready      out_index, out_value, last
//  cfg      in   cfg_we_i               cfg_idx_i, cfg_wdata_i
// Start and query pop in idle; key: KRD, KMUL, KACC; value: VRD, VACC; one op at a time.
// Key at the last index adds the exp series: up to 64 terms, each one division
// on the shared bit-serial divider, plus a reciprocal division for a negative score.
// Finish: one division per output element, again on the shared divider.
// A 4-entry queue decouples input from the back end; a full output register stalls it.
// Reset is asynchronous; no clearing pass, accumulators use per-entry valid bits.
module exp_weighted_attention_accumulator_core #(
  parameter int MAX_DIM = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ewa_in_if.sink      in_i,
  ewa_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0]    scale_q;
  logic [6:0]     dim_q;
  ewa_pkg::cfg_t  cfg;
  ewa_pkg::item_t head;
  logic           head_vld, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ewa_pkg::SCALE_RST;
      dim_q   <= ewa_pkg::DIM_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ewa_pkg::CFG_SCORE_SCALE) scale_q <= cfg_wdata_i;
      if (cfg_idx_i == ewa_pkg::CFG_DIM_IN_USE) dim_q <= cfg_wdata_i[6:0];
    end
  end

  always_comb begin
    cfg.scale = scale_q;
    if (dim_q == 7'd0) cfg.dim = 7'd1;
    else if (dim_q > 7'(MAX_DIM)) cfg.dim = 7'(MAX_DIM);
    else cfg.dim = dim_q;
  end

  ewa_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .dim_i      (cfg.dim),
    .pop_i      (pop),
    .head_o     (head),
    .head_vld_o (head_vld)
  );

  ewa_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .head_i     (head),
    .head_vld_i (head_vld),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
